>>> rtl/core/bcq_pkg.sv
`timescale 1ns / 1ps
package bcq_pkg;

  localparam int DEF_HISTORY_DEPTH = 5;
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_W-1:0] RST_PRESS_STABLE   = 16'd10;
  localparam logic [CFG_W-1:0] RST_RELEASE_STABLE = 16'd10;
  localparam logic [CFG_W-1:0] RST_MIN_PRESS      = 16'd100;
  localparam logic [CFG_W-1:0] RST_PANIC_WINDOW   = 16'd1000;
  localparam logic [CFG_W-1:0] RST_PANIC_DURATION = 16'd500;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PRESS_STABLE   = 3'd0,
    REG_RELEASE_STABLE = 3'd1,
    REG_MIN_PRESS      = 3'd2,
    REG_PANIC_WINDOW   = 3'd3,
    REG_PANIC_DURATION = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] press_stable_ms;
    logic [CFG_W-1:0] release_stable_ms;
    logic [CFG_W-1:0] min_press_ms;
    logic [CFG_W-1:0] panic_window_ms;
    logic [CFG_W-1:0] panic_duration_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] rotation_ms;
  } in_item_t;

  typedef struct packed {
    logic click;
    logic panic;
  } out_item_t;

endpackage

>>> rtl/core/bcq_ram.sv
`timescale 1ns / 1ps
module bcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 5
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/bcq_core.sv
`timescale 1ns / 1ps
module bcq_core
  import bcq_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output out_item_t result
);

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

  logic                     held, held_next;
  logic                     confirmed, confirmed_next;
  logic                     release_seen, release_seen_next;
  logic [TIME_W-1:0]        press_start, press_start_next;
  logic [TIME_W-1:0]        release_start, release_start_next;
  logic [TIME_W-1:0]        rotation_at_press, rotation_at_press_next;
  logic [HISTORY_DEPTH-1:0] click_valid, click_valid_next;
  logic [SLOT_W-1:0]        history_slot, history_slot_next;
  logic                     panic_active, panic_active_next;
  logic [TIME_W-1:0]        panic_start, panic_start_next;

  logic [TIME_W-1:0] click_time_rd;
  logic              mem_we;

  logic              panic_hold, expire;
  logic [HISTORY_DEPTH-1:0] valid_eff;
  logic [SLOT_W-1:0] slot_eff;
  logic              release_done, qualifies, hit;
  logic              click;

  // history times; next slot is prefetched so every item finds its entry ready
  bcq_ram #(
    .WIDTH (TIME_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_eff),
    .wdata (item.now_ms),
    .raddr (history_slot_next),
    .rdata (click_time_rd)
  );

  always_comb begin
    panic_hold = panic_active &&
                 ((item.now_ms - panic_start) < {16'b0, cfg.panic_duration_ms});
    expire     = panic_active && !panic_hold;
    valid_eff  = expire ? '0 : click_valid;
    slot_eff   = expire ? '0 : history_slot;

    release_done = held && !item.pressed && release_seen &&
                   ((item.now_ms - release_start) >= {16'b0, cfg.release_stable_ms});
    qualifies    = release_done && confirmed &&
                   ((release_start - press_start) >= {16'b0, cfg.min_press_ms}) &&
                   (item.rotation_ms == rotation_at_press);
    hit          = valid_eff[slot_eff] &&
                   ((item.now_ms - click_time_rd) < {16'b0, cfg.panic_window_ms});

    held_next              = held;
    confirmed_next         = confirmed;
    release_seen_next      = release_seen;
    press_start_next       = press_start;
    release_start_next     = release_start;
    rotation_at_press_next = rotation_at_press;
    click_valid_next       = click_valid;
    history_slot_next      = history_slot;
    panic_active_next      = panic_active;
    panic_start_next       = panic_start;
    click                  = 1'b0;
    mem_we                 = 1'b0;

    if (take) begin
      if (panic_hold) begin
        held_next         = 1'b0;
        confirmed_next    = 1'b0;
        release_seen_next = 1'b0;
      end else begin
        panic_active_next = 1'b0;
        click_valid_next  = valid_eff;
        history_slot_next = slot_eff;
        if (item.pressed) begin
          if (!held) begin
            held_next              = 1'b1;
            press_start_next       = item.now_ms;
            confirmed_next         = 1'b0;
            rotation_at_press_next = item.rotation_ms;
          end else if (!confirmed &&
                       ((item.now_ms - press_start) >= {16'b0, cfg.press_stable_ms})) begin
            confirmed_next = 1'b1;
          end
          release_seen_next = 1'b0;
        end else if (held) begin
          if (!release_seen) begin
            release_seen_next  = 1'b1;
            release_start_next = item.now_ms;
          end else if (release_done) begin
            if (qualifies) begin
              if (hit) begin
                panic_active_next = 1'b1;
                panic_start_next  = item.now_ms;
              end else begin
                mem_we                     = 1'b1;
                click                      = 1'b1;
                click_valid_next[slot_eff] = 1'b1;
                history_slot_next = (slot_eff == LAST_SLOT) ? '0 : slot_eff + 1'b1;
              end
            end
            held_next         = 1'b0;
            confirmed_next    = 1'b0;
            release_seen_next = 1'b0;
          end
        end
      end
    end

    if (rst) begin
      history_slot_next = '0;
    end

    result.click = click;
    result.panic = panic_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held              <= 1'b0;
      confirmed         <= 1'b0;
      release_seen      <= 1'b0;
      press_start       <= '0;
      release_start     <= '0;
      rotation_at_press <= '0;
      click_valid       <= '0;
      history_slot      <= '0;
      panic_active      <= 1'b0;
      panic_start       <= '0;
    end else begin
      held              <= held_next;
      confirmed         <= confirmed_next;
      release_seen      <= release_seen_next;
      press_start       <= press_start_next;
      release_start     <= release_start_next;
      rotation_at_press <= rotation_at_press_next;
      click_valid       <= click_valid_next;
      history_slot      <= history_slot_next;
      panic_active      <= panic_active_next;
      panic_start       <= panic_start_next;
    end
  end

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (slot_eff != history_slot_next))
    else $error("history write collides with prefetch read");

  a_click_not_panic: assert property (@(posedge clk) disable iff (rst)
    (take && click) |-> !panic_active_next)
    else $error("click issued together with panic");

  a_expire_clears: assert property (@(posedge clk) disable iff (rst)
    (take && expire) |=> ($countones(click_valid) <= 1))
    else $error("history not cleared at end of panic");

  a_hold_drops_press: assert property (@(posedge clk) disable iff (rst)
    (take && panic_hold) |=> (!held && !confirmed && panic_active))
    else $error("press tracking kept during panic");

endmodule

>>> rtl/core/bcq_outbuf.sv
`timescale 1ns / 1ps
module bcq_outbuf
  import bcq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  out_item_t result_in,
  output logic      full,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  logic      skid_valid;
  out_item_t skid;
  logic      drain;

  assign drain = result_valid && !result_stall;
  assign full  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        result       <= skid;
        skid_valid   <= 1'b0;
      end
    end else if (take) begin
      if (!result_valid || drain) begin
        result       <= result_in;
        result_valid <= 1'b1;
      end else begin
        skid       <= result_in;
        skid_valid <= 1'b1;
      end
    end else if (drain) begin
      result_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/button_click_qualifier_unit.sv
`timescale 1ns / 1ps
// Qualifies clicks of one push button. One tick item (button level, time, last
// rotation time) is taken every clock cycle unless stalled, and gives exactly
// one result item (click, panic). Click times live in a small synchronous RAM
// whose entry for the next history slot is fetched while the current item is
// processed, so ticks can run back to back at one per cycle. A two-entry output
// buffer lets one more tick be taken while a result is stalled. Configuration
// writes are always ready and take effect on the next item.
module button_click_qualifier_unit
  import bcq_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  in_item_t               item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output out_item_t              result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cfg_regs_t cfg;
  out_item_t core_result;
  logic      take;
  logic      full;

  assign cfg_ready  = 1'b1;
  assign item_stall = full;
  assign take       = item_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_stable_ms   <= RST_PRESS_STABLE;
      cfg.release_stable_ms <= RST_RELEASE_STABLE;
      cfg.min_press_ms      <= RST_MIN_PRESS;
      cfg.panic_window_ms   <= RST_PANIC_WINDOW;
      cfg.panic_duration_ms <= RST_PANIC_DURATION;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRESS_STABLE:   cfg.press_stable_ms   <= cfg_data;
        REG_RELEASE_STABLE: cfg.release_stable_ms <= cfg_data;
        REG_MIN_PRESS:      cfg.min_press_ms      <= cfg_data;
        REG_PANIC_WINDOW:   cfg.panic_window_ms   <= cfg_data;
        REG_PANIC_DURATION: cfg.panic_duration_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  bcq_core #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (item),
    .cfg    (cfg),
    .result (core_result)
  );

  bcq_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .result_in    (core_result),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
